// ===== rtl/strh_pkg.sv =====
package strh_pkg;

  localparam logic [31:0] HASH_SEED  = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;
  localparam logic [31:0] FMIX_C1    = 32'h85EBCA6B;
  localparam logic [31:0] FMIX_C2    = 32'hC2B2AE35;

  localparam logic [7:0]  UTF8_CONT_MASK = 8'hC0;
  localparam logic [7:0]  UTF8_CONT_TAG  = 8'h80;
  localparam logic [15:0] HI_SURR_LO     = 16'hD800;
  localparam logic [15:0] HI_SURR_HI     = 16'hDBFF;
  localparam logic [15:0] LO_SURR_LO     = 16'hDC00;
  localparam logic [15:0] LO_SURR_HI     = 16'hDFFF;

  typedef enum logic [1:0] {
    MODE_UTF8  = 2'd0,
    MODE_UTF16 = 2'd1,
    MODE_UTF32 = 2'd2,
    MODE_RAW   = 2'd3
  } char_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_FMIX1,
    ST_FMIX2,
    ST_DONE
  } strh_state_t;

  typedef struct packed {
    logic [31:0] unit;
    logic        finish;
  } in_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [31:0] byte_length;
    logic [31:0] char_length;
  } out_t;

  // operand pair for the shared multiplier
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

// ===== rtl/strh_mul.sv =====
module strh_mul
  import strh_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [31:0] prod_r
);

  logic [31:0] prod_nxt;

  // low word of the product only, mod 2^32
  assign prod_nxt = req.a * req.b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/string_hash_fnv_fmix.sv =====
// string hash engine: fnv-style multiply-add per code unit, fmix32 finalizer
//
// input channel (in_valid / in_stall / in_data): one code unit per transaction.
//   in_data.finish ends the string; in utf-8/16/32 modes a zero unit does too.
// result channel (out_valid / out_stall / out_data): one transaction per
//   string, carrying the finalized hash, the byte length and the char length.
// config: cfg_we writes cfg_wdata into the 2-bit character mode; write it
//   only while no string is in flight.
// timing: one 32x32 multiplier (low word) is shared by the absorb step and
//   both fmix multiplies, under a five-state sequencer.
//   - a hashed unit: the accept cycle starts hash*prime, the
//     next cycle adds the unit. a low surrogate after a high one is not hashed.
//   - a string end passes idle, fmix1, fmix2 and done: xor-shift and multiply
//     by c1, xor-shift and multiply by c2, final xor-shift, then the load of
//     the output register, which raises out_valid.
// in_stall is high whenever the sequencer is busy.
// reset (rst_n low, synchronous): mode back to utf-8, hash back to the seed,
//   counters and surrogate flag cleared, output register empty.
// receiver stall: the result sits in the output register; a following string
//   still hashes, and its end waits in the done state until the slot frees.
module string_hash_fnv_fmix
  import strh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  strh_state_t state_r, state_nxt;
  char_mode_t  mode_r;

  logic [31:0] hash_r, hash_nxt;       // running hash, scratch during fmix
  logic [31:0] byte_cnt_r, byte_cnt_nxt;
  logic [31:0] char_cnt_r, char_cnt_nxt;
  logic        after_hi_r, after_hi_nxt;
  logic [31:0] u_r, u_nxt;             // unit waiting for the add step
  logic [31:0] byte_len_r, byte_len_nxt;
  logic [31:0] char_len_r, char_len_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  mul_req_t    mul_req;
  logic [31:0] prod_r;

  logic        in_acc;
  logic        out_free;

  // decode of the incoming unit
  logic [31:0] dec_u;
  logic [31:0] dec_width;
  logic [31:0] dec_byte_inc;
  logic        dec_term;
  logic        dec_absorb;
  logic        dec_char;
  logic        dec_set_hi;

  strh_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    logic is_lo_surr;
    dec_u        = in_data.unit;
    dec_width    = 32'd0;
    dec_byte_inc = 32'd1;
    dec_char     = 1'b0;
    dec_set_hi   = 1'b0;
    is_lo_surr   = 1'b0;
    case (mode_r)
      MODE_UTF8: begin
        dec_u     = {24'd0, in_data.unit[7:0]};
        dec_width = 32'd1;
        dec_char  = (in_data.unit[7:0] & UTF8_CONT_MASK) != UTF8_CONT_TAG;
      end
      MODE_UTF16: begin
        dec_u        = {16'd0, in_data.unit[15:0]};
        dec_width    = 32'd2;
        dec_byte_inc = 32'd2;
        is_lo_surr   = after_hi_r &&
                       (in_data.unit[15:0] inside {[LO_SURR_LO:LO_SURR_HI]});
        dec_char     = !is_lo_surr;
        dec_set_hi   = !is_lo_surr &&
                       (in_data.unit[15:0] inside {[HI_SURR_LO:HI_SURR_HI]});
      end
      MODE_UTF32: begin
        dec_width    = 32'd4;
        dec_byte_inc = 32'd4;
        dec_char     = 1'b1;
      end
      MODE_RAW: begin
        dec_u = {24'd0, in_data.unit[7:0]};
      end
      default: begin
        dec_u = in_data.unit;
      end
    endcase
    dec_term   = in_data.finish || (mode_r != MODE_RAW && dec_u == 32'd0);
    dec_absorb = !dec_term && !is_lo_surr;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && dec_term) begin
          state_nxt = ST_FMIX1;
        end else if (in_acc && dec_absorb) begin
          state_nxt = ST_ABSORB;
        end
      end
      ST_ABSORB: state_nxt = ST_IDLE;
      ST_FMIX1:  state_nxt = ST_FMIX2;
      ST_FMIX2:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operands
  always_comb begin
    logic [31:0] mix13;
    mix13   = prod_r ^ (prod_r >> 13);
    in_stall = 1'b1;
    mul_req  = '{a: hash_r, b: HASH_PRIME};
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (dec_term) begin
          mul_req = '{a: hash_r ^ (hash_r >> 16), b: FMIX_C1};
        end
      end
      ST_FMIX1: mul_req = '{a: mix13, b: FMIX_C2};
      default:  mul_req = '{a: hash_r, b: HASH_PRIME};
    endcase
  end

  // datapath
  always_comb begin
    hash_nxt      = hash_r;
    byte_cnt_nxt  = byte_cnt_r;
    char_cnt_nxt  = char_cnt_r;
    after_hi_nxt  = after_hi_r;
    u_nxt         = u_r;
    byte_len_nxt  = byte_len_r;
    char_len_nxt  = char_len_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (dec_term) begin
            // lengths are captured now, the counters restart for the next string
            byte_len_nxt = byte_cnt_r + dec_width;
            char_len_nxt = (mode_r == MODE_RAW) ? 32'd0 : char_cnt_r;
            byte_cnt_nxt = 32'd0;
            char_cnt_nxt = 32'd0;
            after_hi_nxt = 1'b0;
          end else begin
            u_nxt        = dec_u;
            byte_cnt_nxt = byte_cnt_r + dec_byte_inc;
            char_cnt_nxt = char_cnt_r + {31'd0, dec_char};
            after_hi_nxt = dec_set_hi;
          end
        end
      end
      ST_ABSORB: hash_nxt = prod_r + u_r;
      ST_FMIX2:  hash_nxt = prod_r ^ (prod_r >> 16);
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{hash_value: hash_r, byte_length: byte_len_r,
                            char_length: char_len_r};
          hash_nxt      = HASH_SEED;
        end
      end
      default: begin
        hash_nxt = hash_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_UTF8;
      hash_r      <= HASH_SEED;
      byte_cnt_r  <= 32'd0;
      char_cnt_r  <= 32'd0;
      after_hi_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      char_cnt_r  <= char_cnt_nxt;
      after_hi_r  <= after_hi_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= char_mode_t'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    byte_len_r <= byte_len_nxt;
    char_len_r <= char_len_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a string end always walks into the finalizer
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dec_term) |=> state_r == ST_FMIX1)
    else $error("string end did not start fmix");

  // counters are already restarted while the result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> (byte_cnt_r == 32'd0 && char_cnt_r == 32'd0 && !after_hi_r))
    else $error("counters not cleared at string end");

  // leaving done restores the seed
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && state_nxt == ST_IDLE) |=> hash_r == HASH_SEED)
    else $error("hash seed not restored");

  // a new result only comes from the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result loaded outside done state");

endmodule
